[hdl/atmf_pkg.sv]
// ----------------------------------------------------------------------------
// atmf_pkg
// Shared types and constants of the ADC trimmed-mean filter.
// ----------------------------------------------------------------------------
package atmf_pkg;

  localparam int CHANNEL_BITS = 3;
  localparam int SAMPLE_BITS  = 12;
  localparam int MEAN_BITS    = 16;
  localparam int FRAC_BITS    = 4;
  localparam int SUM_BITS     = 32;
  localparam int TRIM_COUNT   = 2;

  localparam int DEF_CHANNELS = 8;
  localparam int DEF_WINDOW   = 16;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] channel;
    logic [SAMPLE_BITS-1:0]  sample;
    logic                    last_in_scan;
  } sample_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] out_channel;
    logic [MEAN_BITS-1:0]    mean_q4;
    logic                    window_done;
  } mean_t;

endpackage

[hdl/atmf_stream_if.sv]
// ----------------------------------------------------------------------------
// atmf_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface atmf_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[hdl/adc_trimmed_mean_filter.sv]
// ----------------------------------------------------------------------------
// adc_trimmed_mean_filter
// Per-channel trimmed mean (drop max and min) of ADC scans over a window.
// ----------------------------------------------------------------------------
// Accepts one tagged ADC sample per clock cycle while the input is not stalled
// and keeps, for every channel, the sum, maximum and minimum of its samples over
// WINDOW scans. On the final scan of the window each in-range channel sample
// produces one result: the trimmed mean (sum - max - min) / (WINDOW - 2) in
// 1/16 LSB, truncated and saturated at 16 bits; the last_in_scan mark of that
// scan restarts the window. The per-channel state is updated in the input stage,
// so a sample can be accepted in every cycle unless a result is held there; a
// result passes the input stage, trim stage, reciprocal multiply stage and
// output register in order. Output back-pressure stalls the stages only as far
// as they are full.
// ----------------------------------------------------------------------------
module adc_trimmed_mean_filter #(
  parameter int CHANNELS = atmf_pkg::DEF_CHANNELS,
  parameter int WINDOW   = atmf_pkg::DEF_WINDOW
) (
  input  logic         clk,
  input  logic         rst,
  atmf_stream_if.sink   samples,
  atmf_stream_if.source means
);

  import atmf_pkg::*;

  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SCAN_W     = $clog2(WINDOW);
  localparam int DIVISOR    = WINDOW - TRIM_COUNT;
  localparam int DIV_LOG    = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
  localparam int X_BITS     = MEAN_BITS + DIV_LOG;
  localparam int SHIFT      = X_BITS + DIV_LOG;
  localparam int RECIP_BITS = X_BITS + 1;
  localparam int PROD_BITS  = X_BITS + RECIP_BITS;
  localparam int TRIM_W     = SAMPLE_BITS + 1;

  localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1)
                                       / 64'(DIVISOR);
  localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_FULL);
  localparam logic [SUM_BITS-1:0] SAT_LIMIT =
    SUM_BITS'(DIVISOR) << (MEAN_BITS - FRAC_BITS);
  localparam logic [SCAN_W-1:0] LAST_SCAN = SCAN_W'(WINDOW - 1);

  // per-channel state
  logic [SUM_BITS-1:0]    sum_acc  [CHANNELS];
  logic [SAMPLE_BITS-1:0] max_seen [CHANNELS];
  logic [SAMPLE_BITS-1:0] min_seen [CHANNELS];
  logic [CHANNELS-1:0]    seen;
  logic [SCAN_W-1:0]      scan_count;

  // input stage
  logic    s0_valid;
  sample_t s0_data;

  // trim stage
  logic                    s1_valid;
  logic [CHANNEL_BITS-1:0] s1_channel;
  logic                    s1_last;
  logic [SUM_BITS-1:0]     s1_sum;
  logic [TRIM_W-1:0]       s1_trim;

  // multiply stage
  logic                    s2_valid;
  logic [CHANNEL_BITS-1:0] s2_channel;
  logic                    s2_last;
  logic [X_BITS-1:0]       s2_x;
  logic                    s2_sat;

  // output register
  logic  out_valid;
  mean_t out_data;

  logic s3_ready;
  logic s2_ready;
  logic s1_ready;
  logic s0_ready;
  logic s0_adv;

  logic [CH_IDX_W-1:0]    idx;
  logic                   in_range;
  logic                   final_scan;
  logic                   emit;
  logic                   ch_seen;
  logic [SUM_BITS-1:0]    cur_sum;
  logic [SUM_BITS:0]      sum_wide;
  logic [SUM_BITS-1:0]    sum_next;
  logic [SAMPLE_BITS-1:0] max_next;
  logic [SAMPLE_BITS-1:0] min_next;

  logic [SUM_BITS-1:0]  trim_ext;
  logic [SUM_BITS-1:0]  diff;
  logic                 sat;
  logic [X_BITS-1:0]    x_next;
  logic [PROD_BITS-1:0] prod;
  logic [MEAN_BITS-1:0] mean_next;

  // stage handshakes
  assign s3_ready = !out_valid || means.ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign s0_adv   = s0_valid && (!emit || s1_ready);
  assign s0_ready = !s0_valid || s0_adv;

  assign samples.ready = s0_ready;
  assign means.valid   = out_valid;
  assign means.data    = out_data;

  // per-channel update
  always_comb begin
    idx        = CH_IDX_W'(s0_data.channel);
    in_range   = int'(s0_data.channel) < CHANNELS;
    final_scan = scan_count == LAST_SCAN;
    emit       = in_range && final_scan;
    ch_seen    = seen[idx];
    cur_sum    = ch_seen ? sum_acc[idx] : '0;
    sum_wide   = {1'b0, cur_sum} + (SUM_BITS + 1)'(s0_data.sample);
    sum_next   = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
    max_next   = (!ch_seen || s0_data.sample > max_seen[idx]) ?
                 s0_data.sample : max_seen[idx];
    min_next   = (!ch_seen || s0_data.sample < min_seen[idx]) ?
                 s0_data.sample : min_seen[idx];
  end

  // trim and saturation check
  always_comb begin
    trim_ext = SUM_BITS'(s1_trim);
    diff     = (s1_sum > trim_ext) ? (s1_sum - trim_ext) : '0;
    sat      = diff >= SAT_LIMIT;
    x_next   = X_BITS'(diff << FRAC_BITS);
  end

  // division by the constant trimmed count
  always_comb begin
    prod      = PROD_BITS'(s2_x) * PROD_BITS'(RECIP);
    mean_next = s2_sat ? '1 : prod[SHIFT +: MEAN_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid   <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      out_valid  <= 1'b0;
      seen       <= '0;
      scan_count <= '0;
    end else begin
      if (s0_ready) begin
        s0_valid <= samples.valid;
      end
      if (s1_ready) begin
        s1_valid <= s0_adv && emit;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        out_valid <= s2_valid;
      end
      if (s0_adv) begin
        // end of window clears every channel
        if (s0_data.last_in_scan && final_scan) begin
          seen <= '0;
        end else if (in_range) begin
          seen[idx] <= !final_scan;
        end
        if (s0_data.last_in_scan) begin
          if (final_scan) begin
            scan_count <= '0;
          end else begin
            scan_count <= scan_count + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && samples.valid) begin
      s0_data <= samples.data;
    end
    if (s0_adv && in_range) begin
      sum_acc[idx]  <= sum_next;
      max_seen[idx] <= max_next;
      min_seen[idx] <= min_next;
    end
    if (s0_adv && emit) begin
      s1_channel <= s0_data.channel;
      s1_last    <= s0_data.last_in_scan;
      s1_sum     <= sum_next;
      s1_trim    <= TRIM_W'(max_next) + TRIM_W'(min_next);
    end
    if (s1_valid && s2_ready) begin
      s2_channel <= s1_channel;
      s2_last    <= s1_last;
      s2_x       <= x_next;
      s2_sat     <= sat;
    end
    if (s2_valid && s3_ready) begin
      out_data.out_channel <= s2_channel;
      out_data.mean_q4     <= mean_next;
      out_data.window_done <= s2_last;
    end
  end

endmodule

[hdl/atmf_checker.sv]
// ----------------------------------------------------------------------------
// atmf_checker
// Port-level checks of the ADC trimmed-mean filter, bound to its top level.
// ----------------------------------------------------------------------------
module atmf_checker #(
  parameter int CHANNELS = atmf_pkg::DEF_CHANNELS
) (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input atmf_pkg::mean_t out_data
);

  import atmf_pkg::*;

  // result held until its transfer
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // an empty output side never blocks the input
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with output register empty");

  // results only for configured channels
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(out_data.out_channel) < CHANNELS)
    else $error("result for channel out of range");

  // reset empties the output
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind adc_trimmed_mean_filter atmf_checker #(
  .CHANNELS(CHANNELS)
) u_atmf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (samples.ready),
  .out_valid (means.valid),
  .out_ready (means.ready),
  .out_data  (means.data)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ADC trimmed-mean filter.
// ----------------------------------------------------------------------------
// A queue of tagged samples, a short hand-built window followed by random
// scans, is fed through the sample channel with random gaps. Every transfer
// runs through a local model of the per-channel sum/max/min state, and the
// means that model expects are matched in order against the result channel,
// which is throttled at random as well.
// ----------------------------------------------------------------------------
module testbench;

  import atmf_pkg::*;

  localparam int CHANNELS     = DEF_CHANNELS;
  localparam int WINDOW       = DEF_WINDOW;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
  localparam int MEAN_MAX     = (1 << MEAN_BITS) - 1;
  localparam int TOTAL_ITEMS  = 1450;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PRINT_CAP    = 100;

  logic clk;
  logic rst;

  atmf_stream_if #(.payload_t(sample_t)) samples_if ();
  atmf_stream_if #(.payload_t(mean_t))   means_if ();

  adc_trimmed_mean_filter #(
    .CHANNELS(CHANNELS),
    .WINDOW  (WINDOW)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_if),
    .means  (means_if)
  );

  sample_t sample_q[$];
  mean_t   expected_means[$];

  logic [SUM_BITS-1:0]    chan_sum[CHANNELS];
  logic [SAMPLE_BITS-1:0] chan_max[CHANNELS];
  logic [SAMPLE_BITS-1:0] chan_min[CHANNELS];
  bit                     chan_seen[CHANNELS];
  int                     scans_done;

  int  samples_sent;
  int  means_checked;
  int  windows_closed;
  int  mismatches;
  int  send_gap;
  int  recv_stall;
  int  idle_cycles;
  bit  send_calm;
  bit  recv_calm;
  mean_t predicted;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_channel(int ch);
    chan_sum[ch]  = '0;
    chan_max[ch]  = '0;
    chan_min[ch]  = '0;
    chan_seen[ch] = 1'b0;
  endfunction

  function automatic logic [MEAN_BITS-1:0] trimmed_mean(int ch);
    longint unsigned total;
    longint unsigned trim;
    longint unsigned q;
    total = 64'(chan_sum[ch]);
    trim  = 64'(chan_max[ch]) + 64'(chan_min[ch]);
    if (total <= trim) return '0;
    q = ((total - trim) << FRAC_BITS) / 64'(WINDOW - TRIM_COUNT);
    if (q > 64'(MEAN_MAX)) q = 64'(MEAN_MAX);
    return q[MEAN_BITS-1:0];
  endfunction

  // per-channel window update; returns 1 when the sample yields a mean
  function automatic bit filter_update(input sample_t s, output mean_t m);
    logic [SUM_BITS:0] wide;
    bit final_scan;
    bit hit;
    int ch;
    ch = int'(s.channel);
    final_scan = (scans_done >= WINDOW - 1);
    hit = 1'b0;
    m = '0;
    if (ch < CHANNELS) begin
      wide = {1'b0, chan_sum[ch]} + (SUM_BITS + 1)'(s.sample);
      chan_sum[ch] = wide[SUM_BITS] ? '1 : wide[SUM_BITS-1:0];
      if (!chan_seen[ch]) begin
        chan_max[ch]  = s.sample;
        chan_min[ch]  = s.sample;
        chan_seen[ch] = 1'b1;
      end else begin
        if (s.sample > chan_max[ch]) chan_max[ch] = s.sample;
        if (s.sample < chan_min[ch]) chan_min[ch] = s.sample;
      end
      if (final_scan) begin
        m.out_channel = s.channel;
        m.mean_q4     = trimmed_mean(ch);
        m.window_done = s.last_in_scan;
        clear_channel(ch);
        hit = 1'b1;
      end
    end
    if (s.last_in_scan) begin
      if (final_scan) begin
        for (int c = 0; c < CHANNELS; c++) clear_channel(c);
        scans_done = 0;
        windows_closed++;
      end else begin
        scans_done++;
      end
    end
    return hit;
  endfunction

  task automatic add_sample(int ch, int value, bit last);
    sample_t s;
    s.channel      = CHANNEL_BITS'(ch);
    s.sample       = SAMPLE_BITS'(value);
    s.last_in_scan = last;
    sample_q.push_back(s);
  endtask

  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return SAMPLE_MAX;
      default: return $urandom_range(0, SAMPLE_MAX);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP) $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_mean(input mean_t got);
    mean_t want;
    if (expected_means.size() == 0) begin
      report_mismatch($sformatf("unexpected mean ch %0d value %0d done %0d",
                                got.out_channel, got.mean_q4, got.window_done));
      return;
    end
    want = expected_means.pop_front();
    means_checked++;
    if (got.out_channel !== want.out_channel)
      report_mismatch($sformatf("out_channel %0d, want %0d",
                                got.out_channel, want.out_channel));
    if (got.mean_q4 !== want.mean_q4)
      report_mismatch($sformatf("mean_q4 %0d, want %0d (ch %0d)",
                                got.mean_q4, want.mean_q4, want.out_channel));
    if (got.window_done !== want.window_done)
      report_mismatch($sformatf("window_done %0d, want %0d (ch %0d)",
                                got.window_done, want.window_done, want.out_channel));
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      samples_if.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (samples_if.valid && samples_if.ready) begin
        if (filter_update(samples_if.data, predicted)) expected_means.push_back(predicted);
        samples_sent++;
      end
      if (!samples_if.valid || samples_if.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          samples_if.valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          samples_if.data  <= sample_q.pop_front();
          samples_if.valid <= 1'b1;
          send_gap <= send_calm ? 0 : $urandom_range(0, 9);
          if ($urandom_range(0, 63) == 0) send_calm <= !send_calm;
        end else begin
          samples_if.valid <= 1'b0;
        end
      end
    end
  end

  // mean monitor
  always @(posedge clk) begin
    if (rst) begin
      means_if.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (means_if.valid && means_if.ready) begin
        check_mean(means_if.data);
        recv_stall = recv_calm ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 63) == 0) recv_calm <= !recv_calm;
      end else if (recv_stall != 0) begin
        recv_stall--;
      end
      means_if.ready <= (recv_stall == 0);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((samples_if.valid && samples_if.ready) ||
                 (means_if.valid && means_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d means outstanding",
               idle_cycles, expected_means.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int kind;
    int len;
    rst = 1'b1;
    samples_if.valid = 1'b0;
    samples_if.data  = '0;
    means_if.ready   = 1'b0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    for (int c = 0; c < CHANNELS; c++) clear_channel(c);
    scans_done = 0;

    // one hand-built window, mostly single-sample scans
    add_sample(5, 1234, 1'b0);
    add_sample(0, SAMPLE_MAX, 1'b0);
    add_sample(0, SAMPLE_MAX, 1'b1);
    for (int i = 1; i < WINDOW - 1; i++) add_sample(0, SAMPLE_MAX, 1'b1);
    // final scan: first sighting gives zero, saturated mean, repeat after clear
    add_sample(1, 7, 1'b0);
    add_sample(0, SAMPLE_MAX, 1'b0);
    add_sample(0, 2048, 1'b0);
    add_sample(CHANNELS - 1, 0, 1'b1);

    while (sample_q.size() < TOTAL_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        for (int c = 0; c < CHANNELS; c++) add_sample(c, pick_sample(), c == CHANNELS - 1);
      end else if (kind == 8) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
          add_sample($urandom_range(0, CHANNELS - 1), pick_sample(), i == len - 1);
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          add_sample($urandom_range(0, CHANNELS - 1), pick_sample(),
                     1'($urandom_range(0, 1)));
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (sample_q.size() != 0 || samples_if.valid) @(posedge clk);
    while (expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("fed %0d samples across %0d full windows, checked %0d trimmed means",
             samples_sent, windows_closed, means_checked);
    $display("field mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_means.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[adc_trimmed_mean_filter.f]
hdl/atmf_pkg.sv
hdl/atmf_stream_if.sv
hdl/adc_trimmed_mean_filter.sv
hdl/atmf_checker.sv
test/testbench.sv
